// ===== rtl/vpi_pkg.sv =====
`default_nettype none
package vpi_pkg;

    localparam int unsigned ADDR_W = 5;

    typedef logic signed [31:0] t_q;

    typedef enum logic [2:0] {
        OP_ACCEL   = 3'd0,
        OP_TICK    = 3'd1,
        OP_IMPULSE = 3'd2,
        OP_SET_VEL = 3'd3,
        OP_MOVE    = 3'd4,
        OP_SET_POS = 3'd5,
        OP_CLAMP   = 3'd6
    } t_op;

    localparam logic [2:0] REG_FROZEN  = 3'd0;
    localparam logic [2:0] REG_GRAV_EN = 3'd1;
    localparam logic [2:0] REG_GRAV    = 3'd2;
    localparam logic [2:0] REG_DT_SQ   = 3'd3;
    localparam logic [2:0] REG_DAMPING = 3'd4;

    localparam logic        RST_FROZEN  = 1'b0;
    localparam logic        RST_GRAV_EN = 1'b1;
    localparam t_q          RST_GRAV    = -32'sd642252;
    localparam logic [15:0] RST_DT_SQ   = 16'd73;
    localparam logic [16:0] RST_DAMPING = 17'd65208;

    localparam t_q BOUND_HI = 32'sd131072000;
    localparam t_q BOUND_LO = -32'sd131072000;
    localparam t_q Q_MAX    = 32'sh7fffffff;
    localparam t_q Q_MIN    = 32'sh80000000;

    typedef struct packed {
        logic        frozen;
        logic        grav_en;
        t_q          grav;
        logic [15:0] dt_sq;
        logic [16:0] damping;
    } t_cfg;

    function automatic t_q f_sat33(input logic signed [32:0] v);
        t_q r;
        if (v[32] != v[31]) begin
            r = v[32] ? Q_MIN : Q_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic t_q f_sat34(input logic signed [33:0] v);
        t_q r;
        if ((v[33] == v[32]) && (v[32] == v[31])) begin
            r = v[31:0];
        end else begin
            r = v[33] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

    function automatic t_q f_add(input t_q a, input t_q b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return f_sat33(s);
    endfunction

    function automatic t_q f_sub(input t_q a, input t_q b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        return f_sat33(s);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vpi_if.sv =====
`default_nettype none
interface vpi_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [31:0] vec_x;
    logic [31:0] vec_y;
    logic [31:0] vec_z;

    modport source (output valid, output op, output vec_x, output vec_y, output vec_z,
                    input ready);
    modport sink (input valid, input op, input vec_x, input vec_y, input vec_z,
                  output ready);
endinterface

interface vpi_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output vel_x, output vel_y, output vel_z, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z,
                  input vel_x, input vel_y, input vel_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/verlet_point_integrator.sv =====
`default_nettype none
// channel   direction  payload                          handshake
// i_in      in         op, vec_x, vec_y, vec_z          valid / ready
// o_out     out        pos_x..pos_z, vel_x..vel_z       valid / ready
// apb       in         frozen, gravity, dt_sq, damping  psel / penable, pready high
//
// one item per cycle sustained while o_out does not stall; an item is registered on entry
// and its result is registered in the output register that drives o_out.valid
// per-axis multiply-add (damping and dt_sq products) sets the cycle time
// synchronous active-low reset clears state, control and registers to defaults
// o_out stall holds the result; one more item waits in the input register
module verlet_point_integrator (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    vpi_in_if.sink                          i_in,
    vpi_out_if.source                       o_out,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [vpi_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    vpi_pkg::t_cfg w_cfg;

    logic         r_in_valid;
    vpi_pkg::t_op r_in_op;
    vpi_pkg::t_q  r_in_vec [3];
    vpi_pkg::t_q  r_pos [3];
    vpi_pkg::t_q  r_prev [3];
    vpi_pkg::t_q  r_acc [3];
    logic         r_out_valid;
    vpi_pkg::t_q  r_out_pos [3];
    vpi_pkg::t_q  r_out_vel [3];

    vpi_pkg::t_q  n_pos [3];
    vpi_pkg::t_q  n_prev [3];
    vpi_pkg::t_q  n_acc [3];
    vpi_pkg::t_q  n_vel [3];
    logic [2:0]   w_hit;
    logic         w_hit_any;
    logic         w_adv;
    logic         w_fire;
    logic         w_in_ready;

    vpi_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_fire     = r_in_valid && w_adv;
    assign w_in_ready = !r_in_valid || w_adv;
    assign i_in.ready = w_in_ready;
    assign w_hit_any  = |w_hit;

    for (genvar g = 0; g < 3; g++) begin : g_axis
        vpi_axis u_axis (
            .i_op        (r_in_op),
            .i_frozen    (w_cfg.frozen),
            .i_damping   (w_cfg.damping),
            .i_dt_sq     (w_cfg.dt_sq),
            .i_grav      ((g == 1 && w_cfg.grav_en) ? w_cfg.grav : '0),
            .i_vec       (r_in_vec[g]),
            .i_pos       (r_pos[g]),
            .i_prev      (r_prev[g]),
            .i_acc       (r_acc[g]),
            .i_clamp_lo  ((g == 1) ? '0 : vpi_pkg::BOUND_LO),
            .i_clamp_hit (w_hit_any),
            .o_pos       (n_pos[g]),
            .o_prev      (n_prev[g]),
            .o_acc       (n_acc[g]),
            .o_vel       (n_vel[g]),
            .o_hit       (w_hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i]  <= '0;
                r_prev[i] <= '0;
                r_acc[i]  <= '0;
            end
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                for (int i = 0; i < 3; i++) begin
                    r_pos[i]  <= n_pos[i];
                    r_prev[i] <= n_prev[i];
                    r_acc[i]  <= n_acc[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_in_op     <= vpi_pkg::t_op'(i_in.op);
            r_in_vec[0] <= i_in.vec_x;
            r_in_vec[1] <= i_in.vec_y;
            r_in_vec[2] <= i_in.vec_z;
        end
        if (w_fire) begin
            for (int i = 0; i < 3; i++) begin
                r_out_pos[i] <= n_pos[i];
                r_out_vel[i] <= n_vel[i];
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.pos_x = r_out_pos[0];
    assign o_out.pos_y = r_out_pos[1];
    assign o_out.pos_z = r_out_pos[2];
    assign o_out.vel_x = r_out_vel[0];
    assign o_out.vel_y = r_out_vel[1];
    assign o_out.vel_z = r_out_vel[2];

    a_tick_clears_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_op == vpi_pkg::OP_TICK && !w_cfg.frozen)
        |=> (r_acc[0] == '0 && r_acc[1] == '0 && r_acc[2] == '0))
        else $error("accumulator not cleared by tick");

    a_set_pos_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_op == vpi_pkg::OP_SET_POS)
        |=> (r_out_valid && r_out_vel[0] == '0 && r_out_vel[1] == '0
             && r_out_vel[2] == '0))
        else $error("set position left nonzero velocity");

    a_clamp_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_op == vpi_pkg::OP_CLAMP)
        |=> (r_pos[1] >= 0 && r_pos[1] <= vpi_pkg::BOUND_HI))
        else $error("clamp left y out of range");

    a_held_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_op)))
        else $error("waiting item dropped or changed");

endmodule
`default_nettype wire

// ===== rtl/vpi_cfg.sv =====
`default_nettype none
module vpi_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [vpi_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output vpi_pkg::t_cfg                   o_cfg
);

    vpi_pkg::t_cfg r_cfg;
    logic          w_wr;
    logic [2:0]    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[vpi_pkg::ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frozen  <= vpi_pkg::RST_FROZEN;
            r_cfg.grav_en <= vpi_pkg::RST_GRAV_EN;
            r_cfg.grav    <= vpi_pkg::RST_GRAV;
            r_cfg.dt_sq   <= vpi_pkg::RST_DT_SQ;
            r_cfg.damping <= vpi_pkg::RST_DAMPING;
        end else if (w_wr) begin
            case (w_idx)
                vpi_pkg::REG_FROZEN:  r_cfg.frozen  <= pwdata[0];
                vpi_pkg::REG_GRAV_EN: r_cfg.grav_en <= pwdata[0];
                vpi_pkg::REG_GRAV:    r_cfg.grav    <= pwdata;
                vpi_pkg::REG_DT_SQ:   r_cfg.dt_sq   <= pwdata[15:0];
                vpi_pkg::REG_DAMPING: r_cfg.damping <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            vpi_pkg::REG_FROZEN:  prdata = {31'd0, r_cfg.frozen};
            vpi_pkg::REG_GRAV_EN: prdata = {31'd0, r_cfg.grav_en};
            vpi_pkg::REG_GRAV:    prdata = r_cfg.grav;
            vpi_pkg::REG_DT_SQ:   prdata = {16'd0, r_cfg.dt_sq};
            vpi_pkg::REG_DAMPING: prdata = {15'd0, r_cfg.damping};
            default:              prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/vpi_axis.sv =====
`default_nettype none
module vpi_axis (
    input  wire vpi_pkg::t_op  i_op,
    input  wire logic          i_frozen,
    input  wire logic [16:0]   i_damping,
    input  wire logic [15:0]   i_dt_sq,
    input  wire vpi_pkg::t_q   i_grav,
    input  wire vpi_pkg::t_q   i_vec,
    input  wire vpi_pkg::t_q   i_pos,
    input  wire vpi_pkg::t_q   i_prev,
    input  wire vpi_pkg::t_q   i_acc,
    input  wire vpi_pkg::t_q   i_clamp_lo,
    input  wire logic          i_clamp_hit,
    output vpi_pkg::t_q        o_pos,
    output vpi_pkg::t_q        o_prev,
    output vpi_pkg::t_q        o_acc,
    output vpi_pkg::t_q        o_vel,
    output logic               o_hit
);

    vpi_pkg::t_q        w_acc_g;
    vpi_pkg::t_q        w_vel;
    logic signed [49:0] w_prod_d;
    logic signed [48:0] w_prod_p;
    vpi_pkg::t_q        w_damped;
    vpi_pkg::t_q        w_push;
    vpi_pkg::t_q        w_pos_tick;
    logic               w_lo_hit;
    logic               w_hi_hit;
    vpi_pkg::t_q        w_clamped;
    vpi_pkg::t_q        n_pos;
    vpi_pkg::t_q        n_prev;
    vpi_pkg::t_q        n_acc;

    // damped verlet step, products floored by arithmetic shift
    assign w_acc_g    = vpi_pkg::f_add(i_acc, i_grav);
    assign w_vel      = vpi_pkg::f_sub(i_pos, i_prev);
    assign w_prod_d   = w_vel * $signed({1'b0, i_damping});
    assign w_prod_p   = w_acc_g * $signed({1'b0, i_dt_sq});
    assign w_damped   = vpi_pkg::f_sat34(w_prod_d[49:16]);
    assign w_push     = vpi_pkg::f_sat34({w_prod_p[48], w_prod_p[48:16]});
    assign w_pos_tick = vpi_pkg::f_add(i_pos, vpi_pkg::f_add(w_damped, w_push));

    assign w_lo_hit  = i_pos <= i_clamp_lo;
    assign w_hi_hit  = i_pos >= vpi_pkg::BOUND_HI;
    assign w_clamped = w_lo_hit ? i_clamp_lo : (w_hi_hit ? vpi_pkg::BOUND_HI : i_pos);
    assign o_hit     = w_lo_hit || w_hi_hit;

    always_comb begin
        n_pos  = i_pos;
        n_prev = i_prev;
        n_acc  = i_acc;
        case (i_op)
            vpi_pkg::OP_ACCEL: begin
                n_acc = vpi_pkg::f_add(i_acc, i_vec);
            end
            vpi_pkg::OP_TICK: begin
                if (!i_frozen) begin
                    n_pos  = w_pos_tick;
                    n_prev = i_pos;
                    n_acc  = '0;
                end
            end
            vpi_pkg::OP_IMPULSE: begin
                n_prev = vpi_pkg::f_sub(i_prev, i_vec);
            end
            vpi_pkg::OP_SET_VEL: begin
                n_prev = vpi_pkg::f_sub(i_pos, i_vec);
            end
            vpi_pkg::OP_MOVE: begin
                n_pos  = vpi_pkg::f_add(i_pos, i_vec);
                n_prev = vpi_pkg::f_add(i_prev, i_vec);
            end
            vpi_pkg::OP_SET_POS: begin
                n_pos  = i_vec;
                n_prev = i_vec;
            end
            vpi_pkg::OP_CLAMP: begin
                n_pos = w_clamped;
                if (i_clamp_hit) begin
                    n_prev = w_clamped;
                end
            end
            default: ;
        endcase
    end

    assign o_pos  = n_pos;
    assign o_prev = n_prev;
    assign o_acc  = n_acc;
    assign o_vel  = vpi_pkg::f_sub(n_pos, n_prev);

endmodule
`default_nettype wire

// ===== tb/sv/verlet_point_integrator_tb.sv =====
`timescale 1ns / 1ps
module verlet_point_integrator_tb;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int LAT_CYCLES = 4;
    localparam int RAND_PHASES = 9;
    localparam int RAND_PER_PHASE = 150;

    typedef struct {
        logic [2:0]  op;
        vpi_pkg::t_q v [3];
    } t_op_item;

    typedef struct {
        vpi_pkg::t_q pos [3];
        vpi_pkg::t_q vel [3];
    } t_motion;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel;
    logic penable;
    logic pwrite;
    logic [vpi_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    vpi_in_if in_if ();
    vpi_out_if out_if ();

    verlet_point_integrator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // body state and register copy kept by the predictor
    vpi_pkg::t_q   body_pos [3];
    vpi_pkg::t_q   body_prev [3];
    vpi_pkg::t_q   body_acc [3];
    vpi_pkg::t_cfg body_cfg;

    t_op_item pending [$];
    t_motion  predicted_q [$];

    int queued_cnt = 0;
    int checked_cnt = 0;
    int error_cnt = 0;
    int setting_cnt = 0;
    int tick_cnt = 0;
    int clamp_cnt = 0;
    int clamp_hit_cnt = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit in_quiet = 1'b0;
    bit out_quiet = 1'b0;
    string axis_name [3] = '{"x", "y", "z"};

    function automatic vpi_pkg::t_q clip32(input longint v);
        if (v > longint'(vpi_pkg::Q_MAX)) begin
            return vpi_pkg::Q_MAX;
        end
        if (v < longint'(vpi_pkg::Q_MIN)) begin
            return vpi_pkg::Q_MIN;
        end
        return vpi_pkg::t_q'(v);
    endfunction

    function automatic int pick_pause(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    function automatic vpi_pkg::t_q rand_q(input int near_pct);
        int unsigned r;
        vpi_pkg::t_q edges [6];
        edges = '{vpi_pkg::BOUND_HI, vpi_pkg::BOUND_LO, 32'sd0,
                  vpi_pkg::Q_MAX, vpi_pkg::Q_MIN, -32'sd1};
        r = $urandom_range(0, 99);
        if (r < near_pct) begin
            return vpi_pkg::t_q'(int'(edges[$urandom_range(0, 2)])
                                 + int'($urandom_range(0, 4)) - 2);
        end
        if (r < near_pct + 10) begin
            return edges[$urandom_range(3, 5)];
        end
        if (r < near_pct + 50) begin
            return vpi_pkg::t_q'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
        end
        return vpi_pkg::t_q'($urandom);
    endfunction

    function automatic vpi_pkg::t_cfg rand_cfg();
        vpi_pkg::t_cfg c;
        c.frozen = ($urandom_range(0, 3) == 0);
        c.grav_en = 1'($urandom_range(0, 1));
        c.grav = $urandom_range(0, 1) ? vpi_pkg::t_q'(-int'($urandom_range(0, 2 ** 21)))
                                      : vpi_pkg::t_q'($urandom);
        c.dt_sq = $urandom_range(0, 1) ? 16'($urandom_range(0, 4096)) : 16'($urandom);
        c.damping = $urandom_range(0, 1) ? 17'($urandom_range(60000, 65536))
                                         : 17'($urandom);
        return c;
    endfunction

    // advance the body by one op and queue the position / velocity it yields
    task automatic integrate_item(input t_op_item it);
        t_motion m;
        vpi_pkg::t_q vel;
        vpi_pkg::t_q damped;
        vpi_pkg::t_q push;
        bit hit;
        case (it.op)
            vpi_pkg::OP_ACCEL: begin
                for (int i = 0; i < 3; i++) begin
                    body_acc[i] = clip32(longint'(body_acc[i]) + longint'(it.v[i]));
                end
            end
            vpi_pkg::OP_TICK: begin
                tick_cnt++;
                if (!body_cfg.frozen) begin
                    if (body_cfg.grav_en) begin
                        body_acc[1] = clip32(longint'(body_acc[1]) + longint'(body_cfg.grav));
                    end
                    for (int i = 0; i < 3; i++) begin
                        vel = clip32(longint'(body_pos[i]) - longint'(body_prev[i]));
                        damped = clip32((longint'(vel) * longint'(body_cfg.damping)) >>> 16);
                        push = clip32((longint'(body_acc[i]) * longint'(body_cfg.dt_sq)) >>> 16);
                        body_prev[i] = body_pos[i];
                        body_pos[i] = clip32(longint'(body_pos[i])
                                             + longint'(clip32(longint'(damped)
                                                               + longint'(push))));
                        body_acc[i] = '0;
                    end
                end
            end
            vpi_pkg::OP_IMPULSE: begin
                for (int i = 0; i < 3; i++) begin
                    body_prev[i] = clip32(longint'(body_prev[i]) - longint'(it.v[i]));
                end
            end
            vpi_pkg::OP_SET_VEL: begin
                for (int i = 0; i < 3; i++) begin
                    body_prev[i] = clip32(longint'(body_pos[i]) - longint'(it.v[i]));
                end
            end
            vpi_pkg::OP_MOVE: begin
                for (int i = 0; i < 3; i++) begin
                    body_pos[i] = clip32(longint'(body_pos[i]) + longint'(it.v[i]));
                    body_prev[i] = clip32(longint'(body_prev[i]) + longint'(it.v[i]));
                end
            end
            vpi_pkg::OP_SET_POS: begin
                for (int i = 0; i < 3; i++) begin
                    body_pos[i] = it.v[i];
                    body_prev[i] = it.v[i];
                end
            end
            vpi_pkg::OP_CLAMP: begin
                clamp_cnt++;
                hit = 1'b0;
                if (body_pos[1] <= 0) begin
                    body_pos[1] = '0;
                    hit = 1'b1;
                end
                if (body_pos[1] >= vpi_pkg::BOUND_HI) begin
                    body_pos[1] = vpi_pkg::BOUND_HI;
                    hit = 1'b1;
                end
                for (int i = 0; i < 3; i += 2) begin
                    if (body_pos[i] <= vpi_pkg::BOUND_LO) begin
                        body_pos[i] = vpi_pkg::BOUND_LO;
                        hit = 1'b1;
                    end
                    if (body_pos[i] >= vpi_pkg::BOUND_HI) begin
                        body_pos[i] = vpi_pkg::BOUND_HI;
                        hit = 1'b1;
                    end
                end
                if (hit) begin
                    clamp_hit_cnt++;
                    for (int i = 0; i < 3; i++) begin
                        body_prev[i] = body_pos[i];
                    end
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            m.pos[i] = body_pos[i];
            m.vel[i] = clip32(longint'(body_pos[i]) - longint'(body_prev[i]));
        end
        predicted_q.push_back(m);
    endtask

    task automatic queue_item(input logic [2:0] op, input vpi_pkg::t_q x,
                              input vpi_pkg::t_q y, input vpi_pkg::t_q z);
        t_op_item it;
        it.op = op;
        it.v[0] = x;
        it.v[1] = y;
        it.v[2] = z;
        pending.push_back(it);
        queued_cnt++;
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_body_config(input vpi_pkg::t_cfg c);
        apb_write(vpi_pkg::REG_FROZEN, {31'b0, c.frozen});
        apb_write(vpi_pkg::REG_GRAV_EN, {31'b0, c.grav_en});
        apb_write(vpi_pkg::REG_GRAV, c.grav);
        apb_write(vpi_pkg::REG_DT_SQ, {16'b0, c.dt_sq});
        apb_write(vpi_pkg::REG_DAMPING, {15'b0, c.damping});
        body_cfg = c;
        setting_cnt++;
    endtask

    task automatic wait_drained();
        while (checked_cnt < queued_cnt) begin
            @(posedge i_clk);
        end
        repeat (LAT_CYCLES) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_op_item nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            gap_left = 0;
        end else if (!in_if.valid || in_if.ready) begin
            if ($urandom_range(0, 99) < 2) begin
                in_quiet = ~in_quiet;
            end
            if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (pending.size() > 0) begin
                nxt = pending.pop_front();
                in_if.valid <= 1'b1;
                in_if.op <= nxt.op;
                in_if.vec_x <= nxt.v[0];
                in_if.vec_y <= nxt.v[1];
                in_if.vec_z <= nxt.v[2];
                gap_left = pick_pause(in_quiet);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_op_item seen;
        t_motion got;
        t_motion want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                seen.op = in_if.op;
                seen.v[0] = in_if.vec_x;
                seen.v[1] = in_if.vec_y;
                seen.v[2] = in_if.vec_z;
                integrate_item(seen);
            end
            if (out_if.valid && out_if.ready) begin
                got.pos[0] = out_if.pos_x;
                got.pos[1] = out_if.pos_y;
                got.pos[2] = out_if.pos_z;
                got.vel[0] = out_if.vel_x;
                got.vel[1] = out_if.vel_y;
                got.vel[2] = out_if.vel_z;
                if (predicted_q.size() == 0) begin
                    $display("%0t unexpected item: pos %0d %0d %0d vel %0d %0d %0d", $time,
                             got.pos[0], got.pos[1], got.pos[2],
                             got.vel[0], got.vel[1], got.vel[2]);
                    error_cnt++;
                end else begin
                    want = predicted_q.pop_front();
                    checked_cnt++;
                    for (int k = 0; k < 3; k++) begin
                        if (got.pos[k] !== want.pos[k]) begin
                            $display("%0t pos_%s mismatch: expected %0d actual %0d", $time,
                                     axis_name[k], want.pos[k], got.pos[k]);
                            error_cnt++;
                        end
                        if (got.vel[k] !== want.vel[k]) begin
                            $display("%0t vel_%s mismatch: expected %0d actual %0d", $time,
                                     axis_name[k], want.vel[k], got.vel[k]);
                            error_cnt++;
                        end
                    end
                end
            end
            if ($urandom_range(0, 99) < 2) begin
                out_quiet = ~out_quiet;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                stall_left = pick_pause(out_quiet);
            end
        end
    end

    initial begin
        vpi_pkg::t_cfg c;
        int unsigned r;
        in_if.valid = 1'b0;
        in_if.op = '0;
        in_if.vec_x = '0;
        in_if.vec_y = '0;
        in_if.vec_z = '0;
        out_if.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < 3; i++) begin
            body_pos[i] = '0;
            body_prev[i] = '0;
            body_acc[i] = '0;
        end
        body_cfg.frozen = vpi_pkg::RST_FROZEN;
        body_cfg.grav_en = vpi_pkg::RST_GRAV_EN;
        body_cfg.grav = vpi_pkg::RST_GRAV;
        body_cfg.dt_sq = vpi_pkg::RST_DT_SQ;
        body_cfg.damping = vpi_pkg::RST_DAMPING;
        setting_cnt = 1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: saturation, products and the clamp bounds
        queue_item(vpi_pkg::OP_TICK, 0, 0, 0);
        queue_item(vpi_pkg::OP_ACCEL, vpi_pkg::Q_MAX, vpi_pkg::Q_MIN, 1);
        queue_item(vpi_pkg::OP_ACCEL, vpi_pkg::Q_MAX, vpi_pkg::Q_MIN, -1);
        queue_item(vpi_pkg::OP_TICK, 0, 0, 0);
        queue_item(vpi_pkg::OP_SET_POS, vpi_pkg::Q_MAX, vpi_pkg::Q_MIN, 0);
        queue_item(vpi_pkg::OP_MOVE, 1, -1, 32'sh7fff0000);
        queue_item(vpi_pkg::OP_SET_VEL, vpi_pkg::Q_MIN, vpi_pkg::Q_MAX, 32'sh12345678);
        queue_item(vpi_pkg::OP_IMPULSE, vpi_pkg::Q_MAX, vpi_pkg::Q_MIN, vpi_pkg::Q_MIN);
        queue_item(vpi_pkg::OP_TICK, 0, 0, 0);
        queue_item(vpi_pkg::OP_CLAMP, 0, 0, 0);
        queue_item(vpi_pkg::OP_SET_POS, vpi_pkg::BOUND_HI, 0, vpi_pkg::BOUND_LO);
        queue_item(vpi_pkg::OP_SET_VEL, 100, -100, 7);
        queue_item(vpi_pkg::OP_CLAMP, 0, 0, 0);
        queue_item(vpi_pkg::OP_SET_POS, vpi_pkg::BOUND_HI - 1, 1, vpi_pkg::BOUND_LO + 1);
        queue_item(vpi_pkg::OP_SET_VEL, 5, 5, 5);
        queue_item(vpi_pkg::OP_CLAMP, 0, 0, 0);
        queue_item(vpi_pkg::OP_SET_POS, -1, vpi_pkg::BOUND_HI + 1, vpi_pkg::Q_MIN);
        queue_item(vpi_pkg::OP_CLAMP, 0, 0, 0);
        queue_item(OP_UNUSED, 32'shdeadbeef, 1, 32'sh80000001);
        queue_item(vpi_pkg::OP_TICK, 0, 0, 0);
        wait_drained();

        // frozen body keeps its accumulator across a tick
        c = body_cfg;
        c.frozen = 1'b1;
        load_body_config(c);
        queue_item(vpi_pkg::OP_ACCEL, 65536, -65536, 3);
        queue_item(vpi_pkg::OP_TICK, 0, 0, 0);
        queue_item(OP_UNUSED, 0, 0, 0);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            c = rand_cfg();
            case (ph)
                0: begin
                    c.frozen = 1'b0;
                    c.grav_en = 1'b1;
                    c.grav = vpi_pkg::RST_GRAV;
                    c.dt_sq = 16'hffff;
                    c.damping = 17'd65536;
                end
                1: begin
                    c.frozen = 1'b0;
                    c.grav_en = 1'b0;
                    c.grav = vpi_pkg::Q_MIN;
                    c.dt_sq = '0;
                    c.damping = '0;
                end
                2: begin
                    c.frozen = 1'b0;
                    c.grav_en = 1'b1;
                    c.grav = vpi_pkg::Q_MAX;
                    c.dt_sq = 16'hffff;
                    c.damping = 17'h1ffff;
                end
                3: begin
                    c.frozen = 1'b1;
                end
                4: begin
                    c.frozen = 1'b0;
                    c.grav_en = 1'b1;
                    c.grav = vpi_pkg::Q_MIN;
                    c.dt_sq = 16'hffff;
                    c.damping = 17'd65535;
                end
                default: begin
                end
            endcase
            load_body_config(c);
            if (ph == 0) begin
                queue_item(vpi_pkg::OP_TICK, 0, 0, 0);
            end
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    queue_item(vpi_pkg::OP_TICK, rand_q(15), rand_q(15), rand_q(15));
                end else if (r < 48) begin
                    queue_item(vpi_pkg::OP_ACCEL, rand_q(15), rand_q(15), rand_q(15));
                end else if (r < 58) begin
                    queue_item(vpi_pkg::OP_CLAMP, rand_q(15), rand_q(15), rand_q(15));
                end else if (r < 66) begin
                    queue_item(vpi_pkg::OP_IMPULSE, rand_q(15), rand_q(15), rand_q(15));
                end else if (r < 74) begin
                    queue_item(vpi_pkg::OP_SET_VEL, rand_q(15), rand_q(15), rand_q(15));
                end else if (r < 82) begin
                    queue_item(vpi_pkg::OP_MOVE, rand_q(15), rand_q(15), rand_q(15));
                end else if (r < 94) begin
                    queue_item(vpi_pkg::OP_SET_POS, rand_q(45), rand_q(45), rand_q(45));
                end else begin
                    queue_item(OP_UNUSED, rand_q(15), rand_q(15), rand_q(15));
                end
            end
            wait_drained();
        end

        $display("ran %0d items over %0d register settings, %0d results checked",
                 queued_cnt, setting_cnt, checked_cnt);
        $display("%0d ticks, %0d clamps of which %0d hit a bound",
                 tick_cnt, clamp_cnt, clamp_hit_cnt);
        if (error_cnt == 0 && predicted_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d of %0d results checked", checked_cnt, queued_cnt);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
